// ----- hw/rtl/ccws_pkg.sv -----
// Package for the character class word splitter: word types, codes and constants.
`default_nettype none

package ccws_pkg;

  // Default alphabet size: every byte code can be a word character
  localparam int unsigned ALPHABET_SIZE_DEF = 256;

  // Spec bytes with a meaning of their own
  localparam logic [7:0] CARET_CODE = 8'h5E;
  localparam logic [7:0] DASH_CODE  = 8'h2D;

  // Input action codes
  localparam logic ACT_SPEC = 1'b0;
  localparam logic ACT_TEXT = 1'b1;

  // Result kind codes
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Input word
  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
    logic       last;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic       kind;
    logic [7:0] word_char;
    logic       word_begin;
    logic       word_finish;
    logic       run_last;
  } out_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // take the input word, start the table read
    logic fill_init;  // set up the whole-table fill at spec start
    logic norm_init;  // set up a single mark or a range fill
    logic step;       // one table write of the running sweep
    logic spec_end;   // close a spec byte
    logic lookup;     // classify the text byte, queue its results
    logic emit;       // move the next queued result into the output register
  } ccws_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_text;     // word on the input is a text byte
    logic at_start;    // next spec byte opens a spec
    logic complement;  // current spec is complemented
    logic sweep_done;  // nothing left to write in the sweep
    logic pend_none;   // no result queued
    logic pend_one;    // exactly one result queued
    logic out_free;    // output register can take a word this cycle
  } ccws_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/char_class_word_splitter.sv -----
// Top level of the character class word splitter.
//
//   channel | direction | handshake               | word
//   --------+-----------+-------------------------+---------------------
//   in      | input     | in_valid_i/in_stall_o   | ccws_pkg::in_word_t
//   out     | output    | out_valid_o/out_stall_i | ccws_pkg::out_word_t
//
// One word is worked on at a time, and the next word is taken while its last
// result waits. A spec byte writes the table entries of its sweep; a spec's
// first byte first fills the whole table, and a leading caret ends with that
// fill. After reset a clearing pass over the table runs before the first word
// is taken. A stalled output holds the block in result output.
`default_nettype none

module char_class_word_splitter #(
  parameter int unsigned ALPHABET_SIZE = ccws_pkg::ALPHABET_SIZE_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire ccws_pkg::in_word_t  in_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output ccws_pkg::out_word_t      out_o
);

  ccws_pkg::ccws_cmd_t cmd;
  ccws_pkg::ccws_sts_t sts;

  // Sequencer
  ccws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Table, state and result path
  ccws_datapath #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/ccws_ram.sv -----
// Generic single write port RAM with a registered read port.
`default_nettype none

module ccws_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ccws_datapath.sv -----
// Datapath of the word splitter: class table, spec and text state, result queue.
`default_nettype none

module ccws_datapath #(
  parameter int unsigned ALPHABET_SIZE = ccws_pkg::ALPHABET_SIZE_DEF,
  localparam int unsigned AW = $clog2(ALPHABET_SIZE)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ccws_pkg::in_word_t  in_i,
  input  wire logic                out_stall_i,
  output logic                     out_valid_o,
  output ccws_pkg::out_word_t      out_o,
  input  wire ccws_pkg::ccws_cmd_t cmd_i,
  output ccws_pkg::ccws_sts_t      sts_o
);

  localparam logic [8:0] ALPHA = 9'(ALPHABET_SIZE);

  // Input word under work
  ccws_pkg::in_word_t item_q;

  // Spec state
  logic       at_start_q, at_start_d;
  logic       complement_q, complement_d;
  logic [7:0] prev_q, prev_d;
  logic       prev_valid_q, prev_valid_d;
  logic       range_pend_q, range_pend_d;

  // Table write sweep: cnt runs up to hi, writing val
  logic [8:0] cnt_q, cnt_d;
  logic [8:0] hi_q, hi_d;
  logic       val_q, val_d;
  logic       wr_active;

  // Text state
  logic [7:0] held_char_q, held_char_d;
  logic       held_valid_q, held_valid_d;
  logic       held_begins_q, held_begins_d;

  // Result queue: slot 0 held char, slot 1 new char, slot 2 end marker
  logic [2:0] pend_q, pend_d;
  logic [7:0] s0_char_q, s0_char_d;
  logic       s0_begin_q, s0_begin_d;
  logic       s0_finish_q, s0_finish_d;
  logic       s1_begin_q, s1_begin_d;

  // Output register
  logic                out_valid_q, out_valid_d;
  ccws_pkg::out_word_t out_q, out_d;

  logic       tbl_rdata;
  logic       is_word;
  logic       in_range;
  logic [2:0] pend_left;

  // Class table
  ccws_ram #(
    .WIDTH (1),
    .DEPTH (ALPHABET_SIZE)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.step && wr_active),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (val_q),
    .re_i    (cmd_i.load),
    .raddr_i (in_i.data_byte[AW-1:0]),
    .rdata_o (tbl_rdata)
  );

  assign wr_active = (cnt_q <= hi_q) && (cnt_q < ALPHA);
  assign in_range  = {1'b0, item_q.data_byte} < ALPHA;
  assign is_word   = tbl_rdata && in_range;

  // Spec handling and table sweep
  always_comb begin
    at_start_d   = at_start_q;
    complement_d = complement_q;
    prev_d       = prev_q;
    prev_valid_d = prev_valid_q;
    range_pend_d = range_pend_q;
    cnt_d        = cnt_q;
    hi_d         = hi_q;
    val_d        = val_q;
    if (cmd_i.step && wr_active) begin
      cnt_d = cnt_q + 9'd1;
    end
    if (cmd_i.fill_init) begin
      // whole table takes the complement flag; a caret is consumed
      complement_d = (item_q.data_byte == ccws_pkg::CARET_CODE);
      prev_d       = '0;
      prev_valid_d = 1'b0;
      range_pend_d = 1'b0;
      cnt_d        = '0;
      hi_d         = ALPHA - 9'd1;
      val_d        = (item_q.data_byte == ccws_pkg::CARET_CODE);
    end
    if (cmd_i.norm_init) begin
      val_d = !complement_q;
      if (range_pend_q) begin
        // range closes: previous char plus one up to this byte
        cnt_d        = {1'b0, prev_q} + 9'd1;
        hi_d         = {1'b0, item_q.data_byte};
        range_pend_d = 1'b0;
        prev_d       = item_q.data_byte;
        prev_valid_d = 1'b1;
      end else if (item_q.data_byte == ccws_pkg::DASH_CODE && prev_valid_q &&
                   !item_q.last) begin
        // range opens, nothing to write
        range_pend_d = 1'b1;
        cnt_d        = 9'd1;
        hi_d         = '0;
      end else begin
        cnt_d        = {1'b0, item_q.data_byte};
        hi_d         = {1'b0, item_q.data_byte};
        prev_d       = item_q.data_byte;
        prev_valid_d = 1'b1;
      end
    end
    if (cmd_i.spec_end) begin
      at_start_d = item_q.last;
    end
  end

  // Text classification and result queue
  always_comb begin
    held_char_d   = held_char_q;
    held_valid_d  = held_valid_q;
    held_begins_d = held_begins_q;
    pend_d        = pend_q;
    s0_char_d     = s0_char_q;
    s0_begin_d    = s0_begin_q;
    s0_finish_d   = s0_finish_q;
    s1_begin_d    = s1_begin_q;
    if (cmd_i.lookup) begin
      pend_d      = {item_q.last, is_word && item_q.last, held_valid_q};
      s0_char_d   = held_char_q;
      s0_begin_d  = held_begins_q;
      s0_finish_d = !is_word;
      s1_begin_d  = !held_valid_q;
      if (item_q.last) begin
        held_char_d   = '0;
        held_valid_d  = 1'b0;
        held_begins_d = 1'b0;
      end else if (is_word) begin
        held_char_d   = item_q.data_byte;
        held_valid_d  = 1'b1;
        held_begins_d = !held_valid_q;
      end else begin
        held_valid_d = 1'b0;
      end
    end
    if (cmd_i.emit) begin
      priority if (pend_q[0]) begin
        pend_d[0] = 1'b0;
      end else if (pend_q[1]) begin
        pend_d[1] = 1'b0;
      end else begin
        pend_d[2] = 1'b0;
      end
    end
  end

  // Next result word: lowest queued slot first
  always_comb begin
    pend_left = pend_q;
    out_d     = out_q;
    priority if (pend_q[0]) begin
      pend_left[0]      = 1'b0;
      out_d.kind        = ccws_pkg::KIND_CHAR;
      out_d.word_char   = s0_char_q;
      out_d.word_begin  = s0_begin_q;
      out_d.word_finish = s0_finish_q;
    end else if (pend_q[1]) begin
      pend_left[1]      = 1'b0;
      out_d.kind        = ccws_pkg::KIND_CHAR;
      out_d.word_char   = item_q.data_byte;
      out_d.word_begin  = s1_begin_q;
      out_d.word_finish = 1'b1;
    end else begin
      pend_left[2]      = 1'b0;
      out_d.kind        = ccws_pkg::KIND_END;
      out_d.word_char   = '0;
      out_d.word_begin  = 1'b0;
      out_d.word_finish = 1'b0;
    end
    out_d.run_last = (pend_left == 3'b000);
    if (!cmd_i.emit) begin
      out_d = out_q;
    end
  end

  // Output register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q    <= 1'b1;
      complement_q  <= 1'b0;
      prev_q        <= '0;
      prev_valid_q  <= 1'b0;
      range_pend_q  <= 1'b0;
      cnt_q         <= '0;
      hi_q          <= ALPHA - 9'd1;
      val_q         <= 1'b0;
      held_char_q   <= '0;
      held_valid_q  <= 1'b0;
      held_begins_q <= 1'b0;
      pend_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      at_start_q    <= at_start_d;
      complement_q  <= complement_d;
      prev_q        <= prev_d;
      prev_valid_q  <= prev_valid_d;
      range_pend_q  <= range_pend_d;
      cnt_q         <= cnt_d;
      hi_q          <= hi_d;
      val_q         <= val_d;
      held_char_q   <= held_char_d;
      held_valid_q  <= held_valid_d;
      held_begins_q <= held_begins_d;
      pend_q        <= pend_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_i;
    end
    s0_char_q   <= s0_char_d;
    s0_begin_q  <= s0_begin_d;
    s0_finish_q <= s0_finish_d;
    s1_begin_q  <= s1_begin_d;
    out_q       <= out_d;
  end

  // Status to the controller
  assign sts_o.in_text    = (in_i.action == ccws_pkg::ACT_TEXT);
  assign sts_o.at_start   = at_start_q;
  assign sts_o.complement = complement_q;
  assign sts_o.sweep_done = !wr_active;
  assign sts_o.pend_none  = (pend_q == 3'b000);
  assign sts_o.pend_one   = $onehot(pend_q);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // A word is never loaded over one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a stalled word");

  // The closing character of a word is only queued with the end marker
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q[1] |-> pend_q[2])
    else $error("new char queued without end marker");

  // Table writes stay inside the alphabet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && wr_active) |-> (cnt_q < ALPHA))
    else $error("table write beyond alphabet");

  // The end marker is always the last result of its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind == ccws_pkg::KIND_END) |->
      (out_q.run_last && out_q.word_char == 8'd0 && !out_q.word_begin &&
       !out_q.word_finish))
    else $error("malformed end marker");

endmodule

`default_nettype wire

// ----- hw/rtl/ccws_ctrl.sv -----
// Controller of the word splitter: sequences table sweeps, lookups and result output.
`default_nettype none

module ccws_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire ccws_pkg::ccws_sts_t sts_i,
  output ccws_pkg::ccws_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPEC,
    ST_FILL,
    ST_NORM,
    ST_LOOKUP,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        // clearing pass over the table after reset
        cmd_o.step = 1'b1;
        if (sts_i.sweep_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.in_text ? ST_LOOKUP : ST_SPEC;
        end
      end
      ST_SPEC: begin
        if (sts_i.at_start) begin
          cmd_o.fill_init = 1'b1;
          state_d         = ST_FILL;
        end else begin
          cmd_o.norm_init = 1'b1;
          state_d         = ST_NORM;
        end
      end
      ST_FILL: begin
        cmd_o.step = 1'b1;
        if (sts_i.sweep_done) begin
          if (sts_i.complement) begin
            cmd_o.spec_end = 1'b1;
            state_d        = ST_IDLE;
          end else begin
            cmd_o.norm_init = 1'b1;
            state_d         = ST_NORM;
          end
        end
      end
      ST_NORM: begin
        cmd_o.step = 1'b1;
        if (sts_i.sweep_done) begin
          cmd_o.spec_end = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.pend_none) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.pend_one) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire
